/* hw/rtl/b36tok_pkg.sv */
// ----------------------------------------------------------------------------
// b36tok_pkg
// shared types, constants and the digit glyph lookup for the base-36 token
// encoder
// ----------------------------------------------------------------------------
package b36tok_pkg;

  localparam int unsigned IdentW   = 32;
  localparam int unsigned CharW    = 7;
  localparam int unsigned DigitW   = 6;
  localparam int unsigned Slots    = 7;
  localparam int unsigned CntW     = 3;
  localparam int unsigned MulInW   = 30;
  localparam int unsigned ProdW    = 60;
  localparam int unsigned QuotW    = 27;

  localparam logic [IdentW-1:0] TokenOffset  = 32'd56;
  localparam logic [DigitW-1:0] TokenRadix   = 6'd36;
  localparam logic [CharW-1:0]  TokenVersion = 7'h31;
  // ceil(2^33 / 9): (x * Recip9) >> 33 == x / 9 for any 30-bit x
  localparam logic [MulInW-1:0] Recip9       = 30'h38E38E39;
  localparam int unsigned       Recip9Shift  = 33;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_FIX,
    ST_VER,
    ST_DIG
  } state_t;

  typedef struct packed {
    logic load;      // capture ident and seed the working value
    logic mul;       // register the reciprocal product
    logic fix;       // form quotient and remainder, store the digit
    logic emit_ver;  // present the version character
    logic emit_dig;  // present the digit at the read pointer
    logic step_out;  // digit beat taken, move the read pointer down
  } dp_cmd_t;

  typedef struct packed {
    logic conv_done; // valid in ST_FIX: this digit is the last one
    logic last_dig;  // read pointer sits on the least significant digit
  } dp_sts_t;

  function automatic logic [CharW-1:0] glyph(input logic [DigitW-1:0] d);
    logic [CharW-1:0] code;
    if (d < 6'd10) begin
      code = 7'd48 + {1'b0, d};
    end else if (d < TokenRadix) begin
      code = 7'd87 + {1'b0, d};
    end else begin
      code = 7'd48;
    end
    return code;
  endfunction

endpackage

/* hw/rtl/b36tok_ctrl.sv */
// ----------------------------------------------------------------------------
// b36tok_ctrl
// sequencer: accept, divide-by-36 loop, then one beat per character
// ----------------------------------------------------------------------------
module b36tok_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  output logic                out_tvalid,
  input  logic                out_tready,
  output b36tok_pkg::dp_cmd_t cmd,
  input  b36tok_pkg::dp_sts_t sts
);

  b36tok_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= b36tok_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    in_tready  = 1'b0;
    out_tvalid = 1'b0;
    case (state_r)
      b36tok_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = b36tok_pkg::ST_MUL;
        end
      end
      b36tok_pkg::ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = b36tok_pkg::ST_FIX;
      end
      b36tok_pkg::ST_FIX: begin
        cmd.fix = 1'b1;
        if (sts.conv_done) begin
          state_nxt = b36tok_pkg::ST_VER;
        end else begin
          state_nxt = b36tok_pkg::ST_MUL;
        end
      end
      b36tok_pkg::ST_VER: begin
        out_tvalid   = 1'b1;
        cmd.emit_ver = 1'b1;
        if (out_tready) begin
          state_nxt = b36tok_pkg::ST_DIG;
        end
      end
      b36tok_pkg::ST_DIG: begin
        out_tvalid   = 1'b1;
        cmd.emit_dig = 1'b1;
        if (out_tready) begin
          cmd.step_out = 1'b1;
          if (sts.last_dig) begin
            state_nxt = b36tok_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = b36tok_pkg::ST_IDLE;
      end
    endcase
  end

  a_accept_starts_div: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r == b36tok_pkg::ST_MUL))
    else $error("accepted ident did not start the division loop");

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input taken while a token is being sent");

  a_last_beat_idles: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && cmd.emit_dig && sts.last_dig)
      |=> (state_r == b36tok_pkg::ST_IDLE))
    else $error("final character did not return to idle");

endmodule

/* hw/rtl/b36tok_dp.sv */
// ----------------------------------------------------------------------------
// b36tok_dp
// working value, reciprocal multiply for /36, digit store and char output
// ----------------------------------------------------------------------------
module b36tok_dp (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic [b36tok_pkg::IdentW-1:0]          in_ident,
  input  b36tok_pkg::dp_cmd_t                    cmd,
  output b36tok_pkg::dp_sts_t                    sts,
  output logic [b36tok_pkg::CharW-1:0]           out_char,
  output logic                                   out_last
);

  logic [b36tok_pkg::IdentW-1:0] work_r;
  logic [b36tok_pkg::ProdW-1:0]  prod_r;
  logic [b36tok_pkg::DigitW-1:0] store_r [b36tok_pkg::Slots];
  logic [b36tok_pkg::CntW-1:0]   cnt_r;
  logic [b36tok_pkg::CntW-1:0]   rd_r;

  logic [b36tok_pkg::QuotW-1:0]  quot;
  logic [b36tok_pkg::IdentW-1:0] q36;
  logic [b36tok_pkg::IdentW-1:0] diff;
  logic [b36tok_pkg::DigitW-1:0] rem;

  // v / 36 == (v >> 2) / 9
  assign quot = prod_r[b36tok_pkg::Recip9Shift +: b36tok_pkg::QuotW];
  assign q36  = {quot, 5'b0} + {3'b0, quot, 2'b0};
  assign diff = work_r - q36;
  assign rem  = diff[b36tok_pkg::DigitW-1:0];

  assign sts.conv_done = (quot == '0) || (cnt_r == 3'(b36tok_pkg::Slots - 1));
  assign sts.last_dig  = (rd_r == '0);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      work_r <= {in_ident[b36tok_pkg::IdentW-2:0], 1'b0} + b36tok_pkg::TokenOffset;
    end else if (cmd.fix) begin
      work_r <= {5'b0, quot};
    end
    if (cmd.mul) begin
      prod_r <= work_r[b36tok_pkg::IdentW-1:2] * b36tok_pkg::Recip9;
    end
    if (cmd.fix) begin
      store_r[cnt_r] <= rem;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      rd_r  <= '0;
    end else begin
      if (cmd.load) begin
        cnt_r <= '0;
      end else if (cmd.fix) begin
        cnt_r <= cnt_r + 3'd1;
        rd_r  <= cnt_r;
      end else if (cmd.step_out && rd_r != '0) begin
        rd_r <= rd_r - 3'd1;
      end
    end
  end

  always_comb begin
    if (cmd.emit_ver) begin
      out_char = b36tok_pkg::TokenVersion;
      out_last = 1'b0;
    end else begin
      out_char = b36tok_pkg::glyph(store_r[rd_r]);
      out_last = cmd.emit_dig && (rd_r == '0);
    end
  end

  a_cnt_steps: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fix |=> (cnt_r == 3'($past(cnt_r) + 3'd1)))
    else $error("digit count did not advance with a stored digit");

  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fix |-> (rem < b36tok_pkg::TokenRadix && diff[b36tok_pkg::IdentW-1:6] == '0))
    else $error("reciprocal division left a remainder out of range");

  a_rd_in_store: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit_dig |-> (rd_r < cnt_r))
    else $error("read pointer beyond the stored digits");

endmodule

/* hw/rtl/id_to_base36_token.sv */
// ----------------------------------------------------------------------------
// id_to_base36_token
// turns a 32-bit identifier into an ascii token: '1' then base-36 digits
// of ident*2+56 (mod 2^32), most significant first, last character flagged
// ----------------------------------------------------------------------------
// sequence: with n digits (1..7), after the accept beat the division loop
//   runs once per digit (the registered reciprocal multiply, then quotient,
//   remainder and digit store), then n+1 output beats follow
// overlap: no new ident is accepted until the last character is taken
// reset: synchronous active-low rst_n returns the sequencer to idle; the
//   digit store is not cleared, every digit is written before it is read
module id_to_base36_token (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] ident
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [6:0] char_code, [7] zero
  output logic        out_tlast   // last_char
);

  b36tok_pkg::dp_cmd_t cmd;
  b36tok_pkg::dp_sts_t sts;
  logic [b36tok_pkg::CharW-1:0] char_code;

  // sequencer: idle -> (mul, fix) per digit -> version beat -> digit beats
  b36tok_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .sts        (sts)
  );

  // datapath: working value, /36 by reciprocal multiply, digit store
  b36tok_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ident (in_tdata),
    .cmd      (cmd),
    .sts      (sts),
    .out_char (char_code),
    .out_last (out_tlast)
  );

  // char code packed into the low seven bits, top bit padded with zero
  assign out_tdata = {1'b0, char_code};

endmodule

/* test/b36tok_check_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b36tok_check_pkg
// token predictor and in-order character scoreboard for the base-36 token
// encoder test
// ----------------------------------------------------------------------------
package b36tok_check_pkg;

  import b36tok_pkg::*;

  localparam logic [CharW-1:0] CharZero   = 7'h30;  // '0'
  localparam logic [CharW-1:0] CharLowerA = 7'h61;  // 'a'

  typedef struct packed {
    logic [CharW-1:0] code;
    logic             last;
  } token_char_t;

  class token_board;
    token_char_t due_chars[$];
    int unsigned errors;

    function new();
      errors = 0;
    endfunction

    // spell out the token for one accepted ident
    function void note_ident(input logic [IdentW-1:0] ident);
      logic [IdentW-1:0] rest;
      logic [DigitW-1:0] digits[$];
      logic [DigitW-1:0] d;
      token_char_t       one;
      rest = {ident[IdentW-2:0], 1'b0} + TokenOffset;
      do begin
        digits.push_back(DigitW'(rest % TokenRadix));
        rest = rest / TokenRadix;
      end while (rest != 0);
      one.code = TokenVersion;
      one.last = 1'b0;
      due_chars.push_back(one);
      // digits were collected least significant first
      while (digits.size() > 0) begin
        d = digits.pop_back();
        one.code = (d < 10) ? CharZero + CharW'(d) : CharLowerA + CharW'(d - 10);
        one.last = (digits.size() == 0);
        due_chars.push_back(one);
      end
    endfunction

    function void check_char(input logic [7:0] data, input logic last);
      token_char_t want;
      if (due_chars.size() == 0) begin
        errors++;
        $display("%0t: unexpected beat, got tdata %h tlast %b", $time, data, last);
        return;
      end
      want = due_chars.pop_front();
      if (data !== {1'b0, want.code} || last !== want.last) begin
        errors++;
        $display("%0t: mismatch, expected tdata %h tlast %b, got tdata %h tlast %b",
                 $time, {1'b0, want.code}, want.last, data, last);
      end
    endfunction

    function int unsigned pending();
      return due_chars.size();
    endfunction
  endclass

endpackage

/* test/id_to_base36_token_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// id_to_base36_token_test
// drives identifiers into the token encoder and checks every character beat
// against a predicted token, with random idling on both sides, a long
// receiver hold-off and a full drain pause
// ----------------------------------------------------------------------------
module id_to_base36_token_test;

  import b36tok_pkg::*;
  import b36tok_check_pkg::*;

  // length of the long receiver hold-off, in cycles
  localparam int unsigned HoldCycles = 90;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_tvalid;
  logic              in_tready;
  logic [IdentW-1:0] in_tdata;   // [31:0] ident
  logic              out_tvalid;
  logic              out_tready;
  logic [7:0]        out_tdata;  // [6:0] char_code, [7] zero
  logic              out_tlast;  // last_char

  // random idling on both sides while set
  bit          idle_on;
  // long receiver hold-off request, taken up once by the sink process
  bit          hold_req;

  token_board board;

  id_to_base36_token dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  // 8 ns period
  always #4 clk = ~clk;

  // overall watchdog, far beyond the slowest legal run
  initial begin
    #2000000;
    $display("** id_to_base36_token: FAILED **");
    $finish;
  end

  // monitors sample at the falling edge, where every signal already holds
  // the value that the next rising edge will take
  always @(negedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      board.note_ident(in_tdata);
    end
    if (rst_n && out_tvalid && out_tready) begin
      board.check_char(out_tdata, out_tlast);
    end
  end

  // result side: ready by default, random stall bursts, and the long
  // hold-off when asked for
  initial begin : sink
    bit hold_done;
    hold_done = 1'b0;
    out_tready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_req && !hold_done) begin
        out_tready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
        hold_done = 1'b1;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // offer one ident and hold it until the beat is taken; returns on the
  // accepting edge
  task automatic send_ident(input logic [IdentW-1:0] ident);
    in_tvalid <= 1'b1;
    in_tdata  <= ident;
    do @(negedge clk); while (!in_tready);
    @(posedge clk);
  endtask

  // sender idle burst between beats
  task automatic sender_gap();
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  // stop offering and wait for every predicted character
  task automatic await_drain();
    in_tvalid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
  endtask

  initial begin : stimulus
    logic [IdentW-1:0] corner_ids[$];
    logic [IdentW-1:0] ident;
    int                n;
    board     = new();
    idle_on   = 1'b1;
    hold_req  = 1'b0;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    corner_ids = '{
      32'h0000_0000,     // smallest ident, value 56
      32'h0000_0001,
      32'hFFFF_FFFF,     // largest ident, wraps
      32'h7FFF_FFE4,     // wraps to zero: single '0' digit
      32'hFFFF_FFE4,     // also wraps to zero
      32'h7FFF_FFF5,     // value 34, single 'y' digit
      32'h7FFF_FFF6,     // value 36, first two-digit value
      32'h7FFF_FFE3,     // largest value, 2^32 - 2, seven digits
      32'hFFFF_FFE3,     // same value from the upper half
      32'd1088391139,    // value 36^6 - 2, six digits 'zzzzzy'
      32'd1088391140,    // value 36^6, first seven-digit value
      32'h8000_0000,
      32'h5555_5555,
      32'hAAAA_AAAA
    };
    foreach (corner_ids[i]) begin
      send_ident(corner_ids[i]);
      sender_gap();
    end

    for (n = 0; n < 100; n++) begin
      case ($urandom_range(0, 9))
        0:       ident = 32'h7FFF_FFE4 + $urandom_range(0, 40);   // near wrap, few digits
        1:       ident = 32'hFFFF_FFC0 + $urandom_range(0, 63);   // top of range, part of it wraps
        2:       ident = $urandom_range(0, 2000);                 // short tokens
        default: ident = $urandom();
      endcase
      // last stretch of the run without any idling
      if (n == 80) begin
        idle_on = 1'b0;
      end
      // receiver holds off for a long while, the block backs up and stalls
      if (n == 30) begin
        hold_req = 1'b1;
      end
      send_ident(ident);
      if (n == 55) begin
        await_drain();
      end else begin
        sender_gap();
      end
    end

    await_drain();
    repeat (40) @(posedge clk);
    if (board.errors == 0) begin
      $display("** id_to_base36_token: PASSED **");
    end else begin
      $display("** id_to_base36_token: FAILED **");
    end
    $finish;
  end

endmodule

/* files.f */
hw/rtl/b36tok_pkg.sv
hw/rtl/b36tok_ctrl.sv
hw/rtl/b36tok_dp.sv
hw/rtl/id_to_base36_token.sv
test/b36tok_check_pkg.sv
test/id_to_base36_token_test.sv
